// ----- rtl/vfc_pkg.sv -----
// Shared types, constants and corner occlusion helpers for the voxel face cull block.
`timescale 1ns / 1ps

package vfc_pkg;

  // Grid size.
  localparam int SIDE_CELLS   = 16;
  localparam int HEIGHT_CELLS = 256;
  localparam int DEPTH        = SIDE_CELLS * HEIGHT_CELLS * SIDE_CELLS;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CELL_W       = 8;

  // Input field widths.
  localparam int X_W = 4;
  localparam int Y_W = 8;
  localparam int Z_W = 4;

  // Signed coordinate wide enough for -1 .. max dimension.
  localparam int MAX_DIM = (SIDE_CELLS > HEIGHT_CELLS) ? SIDE_CELLS : HEIGHT_CELLS;
  localparam int COORD_W = $clog2(MAX_DIM + 1) + 1;

  // 3x3x3 neighborhood, index = ix*9 + iy*3 + iz with each offset in 0..2.
  localparam int CUBE_CELLS = 27;
  localparam int CUBE_IDX_W = $clog2(CUBE_CELLS);
  localparam int OFF_MAX    = 2;
  localparam logic [CUBE_IDX_W-1:0] CUBE_LAST   = CUBE_IDX_W'(CUBE_CELLS - 1);
  localparam logic [CUBE_IDX_W-1:0] CUBE_CENTER = CUBE_IDX_W'(13);

  localparam int FACE_COUNT = 6;
  localparam int FACE_W     = 3;
  localparam int LEVEL_W    = 3;
  localparam int LEVEL_MAX  = 4;

  // Mode codes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MESH  = 1'b1;

  // Neighbor across each face, in face order +Z, -Z, +Y, -Y, +X, -X.
  localparam logic [CUBE_IDX_W-1:0] NORMAL_IDX [FACE_COUNT] = '{
    CUBE_IDX_W'(14), CUBE_IDX_W'(12), CUBE_IDX_W'(16),
    CUBE_IDX_W'(10), CUBE_IDX_W'(22), CUBE_IDX_W'(4)
  };

  // Corner sign codes {sx, sy, sz}, a set bit meaning the positive direction.
  localparam logic [2:0] CORNER_TAB [FACE_COUNT][4] = '{
    '{3'b001, 3'b101, 3'b111, 3'b011},
    '{3'b100, 3'b000, 3'b010, 3'b110},
    '{3'b010, 3'b011, 3'b111, 3'b110},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b101, 3'b100, 3'b110, 3'b111},
    '{3'b000, 3'b001, 3'b011, 3'b010}
  };

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CUBE_CELLS-1:0] cube_t;

  typedef enum logic [2:0] {
    SCAN_CLEAR,
    SCAN_IDLE,
    SCAN_READ,
    SCAN_DRAIN,
    SCAN_HAND
  } scan_state_t;

  typedef struct packed {
    logic              mode;
    logic [X_W-1:0]    cell_x;
    logic [Y_W-1:0]    cell_y;
    logic [Z_W-1:0]    cell_z;
    logic [CELL_W-1:0] block_code;
  } item_t;

  // Finished neighborhood passed from the scanner to the face emitter.
  typedef struct packed {
    logic  valid;
    cube_t cube;
  } cube_hand_t;

  typedef struct packed {
    logic [FACE_W-1:0]        face_dir;
    logic [3:0][LEVEL_W-1:0]  level;
    logic                     last;
  } rec_t;

  function automatic logic in_grid(input coord_t x, input coord_t y, input coord_t z);
    return (x >= 0) && (x < coord_t'(SIDE_CELLS)) &&
           (y >= 0) && (y < coord_t'(HEIGHT_CELLS)) &&
           (z >= 0) && (z < coord_t'(SIDE_CELLS));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y,
                                                  input coord_t z);
    logic [ADDR_W-1:0] ax;
    logic [ADDR_W-1:0] ay;
    logic [ADDR_W-1:0] az;
    ax = ADDR_W'($unsigned(x));
    ay = ADDR_W'($unsigned(y));
    az = ADDR_W'($unsigned(z));
    return ADDR_W'(ax * ADDR_W'(HEIGHT_CELLS * SIDE_CELLS) + ay * ADDR_W'(SIDE_CELLS) + az);
  endfunction

  function automatic logic [CUBE_IDX_W-1:0] cube_idx(input logic [1:0] ix,
                                                     input logic [1:0] iy,
                                                     input logic [1:0] iz);
    return CUBE_IDX_W'(CUBE_IDX_W'(ix) * CUBE_IDX_W'(9) + CUBE_IDX_W'(iy) * CUBE_IDX_W'(3) +
                       CUBE_IDX_W'(iz));
  endfunction

  // Three side neighbors count one each, the corner diagonal counts two.
  function automatic logic [LEVEL_W-1:0] corner_level(input cube_t cube, input logic [2:0] sgn);
    logic [1:0]         ix;
    logic [1:0]         iy;
    logic [1:0]         iz;
    logic [LEVEL_W-1:0] n;
    ix = sgn[2] ? 2'd2 : 2'd0;
    iy = sgn[1] ? 2'd2 : 2'd0;
    iz = sgn[0] ? 2'd2 : 2'd0;
    n = LEVEL_W'(cube[cube_idx(ix, 2'd1, 2'd1)]) +
        LEVEL_W'(cube[cube_idx(2'd1, iy, 2'd1)]) +
        LEVEL_W'(cube[cube_idx(2'd1, 2'd1, iz)]) +
        LEVEL_W'({cube[cube_idx(ix, iy, iz)], 1'b0});
    return (n > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : n;
  endfunction

endpackage

// ----- rtl/vfc_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/vfc_scan.sv -----
// Sequencer that clears the voxel memory, takes writes and reads a cell's 3x3x3 neighborhood.
`timescale 1ns / 1ps

module vfc_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  vfc_pkg::item_t      in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output vfc_pkg::cube_hand_t hand,
  input  logic                hand_take
);
  import vfc_pkg::*;

  scan_state_t state_r, state_nxt;

  coord_t                  base_x_r, base_y_r, base_z_r;
  logic [1:0]              off_x_r, off_y_r, off_z_r;
  logic [CUBE_IDX_W-1:0]   idx_r;
  logic [ADDR_W-1:0]       clr_cnt_r;
  logic                    pend_valid_r;
  logic [CUBE_IDX_W-1:0]   pend_idx_r;
  logic                    pend_in_r;
  cube_t                   cube_r;

  coord_t                  in_x, in_y, in_z;
  coord_t                  scan_x, scan_y, scan_z;
  logic                    scan_in;
  logic                    accept;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [CELL_W-1:0]       ram_wdata;
  logic [CELL_W-1:0]       ram_rdata;

  assign in_x   = coord_t'(COORD_W'(in_item.cell_x));
  assign in_y   = coord_t'(COORD_W'(in_item.cell_y));
  assign in_z   = coord_t'(COORD_W'(in_item.cell_z));
  assign scan_x = base_x_r + coord_t'(COORD_W'(off_x_r)) - coord_t'(1);
  assign scan_y = base_y_r + coord_t'(COORD_W'(off_y_r)) - coord_t'(1);
  assign scan_z = base_z_r + coord_t'(COORD_W'(off_z_r)) - coord_t'(1);
  assign scan_in = in_grid(scan_x, scan_y, scan_z);

  assign in_ready = (state_r == SCAN_IDLE);
  assign accept   = in_valid && in_ready;

  assign hand.valid = (state_r == SCAN_HAND);
  assign hand.cube  = cube_r;

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = cell_addr(scan_x, scan_y, scan_z);
    ram_wdata = in_item.block_code;
    unique case (state_r)
      SCAN_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = SCAN_IDLE;
        end
      end
      SCAN_IDLE: begin
        ram_addr = cell_addr(in_x, in_y, in_z);
        if (accept) begin
          if (in_item.mode == MODE_MESH) begin
            state_nxt = SCAN_READ;
          end else begin
            ram_we = in_grid(in_x, in_y, in_z);
          end
        end
      end
      SCAN_READ: begin
        if (idx_r == CUBE_LAST) begin
          state_nxt = SCAN_DRAIN;
        end
      end
      SCAN_DRAIN: begin
        state_nxt = SCAN_HAND;
      end
      SCAN_HAND: begin
        if (hand_take) begin
          state_nxt = SCAN_IDLE;
        end
      end
      default: begin
        state_nxt = SCAN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SCAN_CLEAR;
      clr_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= (state_r == SCAN_READ);
      if (state_r == SCAN_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Walk order and neighborhood capture; these registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_x_r <= in_x;
      base_y_r <= in_y;
      base_z_r <= in_z;
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      idx_r    <= '0;
    end else if (state_r == SCAN_READ) begin
      idx_r <= idx_r + CUBE_IDX_W'(1);
      if (off_z_r == 2'(OFF_MAX)) begin
        off_z_r <= '0;
        if (off_y_r == 2'(OFF_MAX)) begin
          off_y_r <= '0;
          off_x_r <= off_x_r + 2'd1;
        end else begin
          off_y_r <= off_y_r + 2'd1;
        end
      end else begin
        off_z_r <= off_z_r + 2'd1;
      end
    end
    pend_idx_r <= idx_r;
    pend_in_r  <= scan_in;
    if (pend_valid_r) begin
      cube_r[pend_idx_r] <= pend_in_r && (ram_rdata != '0);
    end
  end

  vfc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The memory is written only while clearing or on a write transaction.
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == SCAN_CLEAR || state_r == SCAN_IDLE))
    else $error("voxel memory written during a neighborhood scan");

  // The neighborhood is complete before it is offered.
  a_hand_done: assert property (@(posedge clk) disable iff (!rst_n)
    hand.valid |-> !pend_valid_r)
    else $error("neighborhood offered with a read still in flight");

  // A scan always ends with the last neighbor read.
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN_READ && state_nxt == SCAN_DRAIN) |-> (off_x_r == 2'(OFF_MAX)))
    else $error("scan left before the last neighborhood plane");

endmodule

// ----- rtl/vfc_emit.sv -----
// Face emitter: picks visible faces one at a time and computes their corner occlusion.
`timescale 1ns / 1ps

module vfc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  vfc_pkg::cube_hand_t hand,
  output logic                hand_take,
  output logic                out_valid,
  input  logic                out_ready,
  output vfc_pkg::rec_t       out_rec
);
  import vfc_pkg::*;

  cube_t                 cube_r;
  logic [FACE_COUNT-1:0] mask_r;
  logic                  out_valid_r;
  rec_t                  out_rec_r;

  logic [FACE_COUNT-1:0] vis;
  logic [FACE_COUNT-1:0] rest;
  logic [FACE_W-1:0]     sel;
  logic                  found;
  logic                  adv;
  rec_t                  rec_nxt;

  assign hand_take = hand.valid && (mask_r == '0);
  assign adv       = (mask_r != '0) && (!out_valid_r || out_ready);

  always_comb begin
    for (int f = 0; f < FACE_COUNT; f++) begin
      vis[f] = hand.cube[CUBE_CENTER] && !hand.cube[NORMAL_IDX[f]];
    end
  end

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int f = 0; f < FACE_COUNT; f++) begin
      if (!found && mask_r[f]) begin
        found = 1'b1;
        sel   = FACE_W'(f);
      end
    end
    rest             = mask_r & ~(FACE_COUNT'(1) << sel);
    rec_nxt.face_dir = sel;
    for (int c = 0; c < 4; c++) begin
      rec_nxt.level[c] = corner_level(cube_r, CORNER_TAB[sel][c]);
    end
    rec_nxt.last = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (hand_take) begin
        mask_r <= vis;
      end else if (adv) begin
        mask_r <= rest;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand_take) begin
      cube_r <= hand.cube;
    end
    if (adv) begin
      out_rec_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  // A cell's neighborhood stays put until all of its faces are out.
  a_cube_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r != '0) |=> $stable(cube_r))
    else $error("neighborhood replaced while faces were pending");

  // A record that is not the last one leaves faces of the same cell pending.
  a_more_faces: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_rec_r.last) |-> (mask_r != '0))
    else $error("record not marked last but no face remains");

endmodule

// ----- rtl/voxel_face_cull_with_corner_occlusion.sv -----
// Top level of the voxel face cull block with per-corner occlusion codes.
`timescale 1ns / 1ps

// The block keeps a 16 x 256 x 16 grid of 8-bit block types (0 is air) in one
// single-port memory. Each input transaction carries mode on in_tuser. In write
// mode the block type is stored in the addressed cell; a cell outside the grid is
// left alone. In mesh mode the block reads the cell and its 26 neighbors, one
// memory read per cycle, and then sends one output transaction per face whose
// neighbor is air, in the order +Z, -Z, +Y, -Y, +X, -X, with out_tlast on the
// final face of the cell. An air cell or an enclosed cell sends nothing.
// A mesh transaction keeps in_tready low after it is accepted, through the memory
// reads, the wait for the last read data and the handoff to the emitter, which waits
// while the emitter is busy; with a single memory port, no new transaction is taken
// while a neighborhood is being read. Faces then leave one per cycle from an output
// register while the receiver does not stall, and meanwhile the next input
// transaction can already be taken. After reset the block clears the whole memory
// to air, one cell per cycle, and in_tready stays low meanwhile. When the receiver
// stalls, the record waits in the output register; a further cell waits for the
// emitter to drain, and the input side then stalls as well.

module voxel_face_cull_with_corner_occlusion (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_x[3:0], cell_y[11:4], cell_z[15:12], block_code[23:16]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // face_dir[2:0], corner_level0[5:3], corner_level1[8:6],
                                  // corner_level2[11:9], corner_level3[14:12], zero[15]
  output logic        out_tlast   // last_face
);
  import vfc_pkg::*;

  item_t      in_item;
  cube_hand_t hand;
  logic       hand_take;
  rec_t       out_rec;

  // Unpack the input transaction.
  assign in_item.mode       = in_tuser;
  assign in_item.cell_x     = in_tdata[3:0];
  assign in_item.cell_y     = in_tdata[11:4];
  assign in_item.cell_z     = in_tdata[15:12];
  assign in_item.block_code = in_tdata[23:16];

  vfc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .hand      (hand),
    .hand_take (hand_take)
  );

  vfc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .hand      (hand),
    .hand_take (hand_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec)
  );

  // Pack the face record.
  assign out_tdata = {1'b0, out_rec.level[3], out_rec.level[2], out_rec.level[1],
                      out_rec.level[0], out_rec.face_dir};
  assign out_tlast = out_rec.last;

endmodule

// ----- tb/tb_voxel_face_cull_with_corner_occlusion.sv -----
// Self-checking testbench for the voxel face cull block with corner occlusion codes.
`timescale 1ns / 1ps

module tb_voxel_face_cull_with_corner_occlusion;

  // Face directions in the order the block emits them.
  typedef enum logic [2:0] {
    FACE_POS_Z,
    FACE_NEG_Z,
    FACE_POS_Y,
    FACE_NEG_Y,
    FACE_POS_X,
    FACE_NEG_X
  } face_t;

  // One expected face transaction. Corner level c sits in lvl[c].
  typedef struct packed {
    face_t           dir;
    logic [3:0][2:0] lvl;
    logic            last;
  } face_rec_t;

  // Step across each face, indexed by face direction.
  localparam int NORMAL_STEP [6][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}
  };

  // Corner offsets (dx, dy, dz) of each face, in the order of the four levels.
  localparam int CORNER_STEP [6][4][3] = '{
    '{'{-1, -1,  1}, '{ 1, -1,  1}, '{ 1,  1,  1}, '{-1,  1,  1}},
    '{'{ 1, -1, -1}, '{-1, -1, -1}, '{-1,  1, -1}, '{ 1,  1, -1}},
    '{'{-1,  1, -1}, '{-1,  1,  1}, '{ 1,  1,  1}, '{ 1,  1, -1}},
    '{'{-1, -1,  1}, '{-1, -1, -1}, '{ 1, -1, -1}, '{ 1, -1,  1}},
    '{'{ 1, -1,  1}, '{ 1, -1, -1}, '{ 1,  1, -1}, '{ 1,  1,  1}},
    '{'{-1, -1, -1}, '{-1, -1,  1}, '{-1,  1,  1}, '{-1,  1, -1}}
  };

  localparam int GRID_SIDE   = vfc_pkg::SIDE_CELLS;
  localparam int GRID_HEIGHT = vfc_pkg::HEIGHT_CELLS;

  // Shadow copy of the voxel grid plus the queue of face records still owed by the block.
  class face_scoreboard;
    bit [7:0]  cells [GRID_SIDE * GRID_HEIGHT * GRID_SIDE];
    face_rec_t faces_due [$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Cells past the grid edge read as air.
    function bit solid_at(int x, int y, int z);
      if (x < 0 || x >= GRID_SIDE || y < 0 || y >= GRID_HEIGHT || z < 0 || z >= GRID_SIDE)
        return 1'b0;
      return cells[(x * GRID_HEIGHT + y) * GRID_SIDE + z] != 8'h00;
    endfunction

    // Each side neighbor counts one, the diagonal counts two, and the sum saturates at four.
    function logic [2:0] occlusion(int x, int y, int z, int dx, int dy, int dz);
      int n;
      n = solid_at(x + dx, y, z) + solid_at(x, y + dy, z) + solid_at(x, y, z + dz) +
          2 * solid_at(x + dx, y + dy, z + dz);
      return (n > 4) ? 3'd4 : 3'(n);
    endfunction

    // Called once per accepted input transaction, in acceptance order.
    function void note_cell_item(logic mode, logic [3:0] cx, logic [7:0] cy, logic [3:0] cz,
                                 logic [7:0] code);
      int        x;
      int        y;
      int        z;
      face_rec_t rec;
      face_rec_t cell_faces [$];
      x = cx;
      y = cy;
      z = cz;
      if (mode == vfc_pkg::MODE_WRITE) begin
        cells[(x * GRID_HEIGHT + y) * GRID_SIDE + z] = code;
        return;
      end
      if (!solid_at(x, y, z))
        return;
      for (int f = 0; f < 6; f++) begin
        if (solid_at(x + NORMAL_STEP[f][0], y + NORMAL_STEP[f][1], z + NORMAL_STEP[f][2]))
          continue;
        rec.dir  = face_t'(f);
        rec.last = 1'b0;
        for (int c = 0; c < 4; c++) begin
          rec.lvl[c] = occlusion(x, y, z, CORNER_STEP[f][c][0], CORNER_STEP[f][c][1],
                                 CORNER_STEP[f][c][2]);
        end
        cell_faces = {cell_faces, rec};
      end
      if (cell_faces.size() > 0)
        cell_faces[cell_faces.size() - 1].last = 1'b1;
      faces_due = {faces_due, cell_faces};
    endfunction

    // Compares one accepted output transaction with the oldest owed face.
    function void check_face(logic [15:0] data, logic last);
      face_rec_t exp_rec;
      if (faces_due.size() == 0) begin
        $error("face transaction with none expected: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      exp_rec = faces_due.pop_front();
      if (data[2:0] !== exp_rec.dir) begin
        $error("face_dir: expected %0d, got %0d", exp_rec.dir, data[2:0]);
        errors++;
      end
      for (int c = 0; c < 4; c++) begin
        if (data[3 + 3 * c +: 3] !== exp_rec.lvl[c]) begin
          $error("corner_level%0d: expected %0d, got %0d", c, exp_rec.lvl[c],
                 data[3 + 3 * c +: 3]);
          errors++;
        end
      end
      if (data[15] !== 1'b0) begin
        $error("tdata pad bit: expected 0, got %b", data[15]);
        errors++;
      end
      if (last !== exp_rec.last) begin
        $error("last_face: expected %b, got %b", exp_rec.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return faces_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // cell_x[3:0], cell_y[11:4], cell_z[15:12], block_code[23:16]
  logic        in_tuser = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // face_dir[2:0], corner_level0..3[14:3], zero[15]
  logic        out_tlast;       // last_face

  face_scoreboard sb;
  bit             calm_tail = 1'b0;  // set near the end: no more gaps or stalls
  int             stall_left = 0;
  bit             stall_ready = 1'b1;

  voxel_face_cull_with_corner_occlusion i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // The receiver mixes random ready and stall bursts, mostly ready,
  // until the calm tail of the run, where it always accepts.
  always @(negedge clk) begin
    if (calm_tail) begin
      out_tready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_ready = ($urandom_range(0, 2) != 0);
        stall_left  = $urandom_range(1, 7);
      end
      out_tready <= stall_ready;
      stall_left--;
    end
  end

  // Every face the block hands over is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_face(out_tdata, out_tlast);
  end

  // Drives one input transaction starting at a falling edge and returns at the falling
  // edge after it was accepted. An optional idle burst comes first.
  task automatic send_item(input logic mode, input logic [3:0] x, input logic [7:0] y,
                           input logic [3:0] z, input logic [7:0] code);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {code, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_cell_item(mode, x, y, z, code);
    @(negedge clk);
  endtask

  task automatic put_cell(input int x, input int y, input int z, input logic [7:0] code);
    send_item(vfc_pkg::MODE_WRITE, 4'(x), 8'(y), 4'(z), code);
  endtask

  // In mesh mode the block code is ignored, so random content rides along.
  task automatic mesh_cell(input int x, input int y, input int z, input logic [7:0] code);
    send_item(vfc_pkg::MODE_MESH, 4'(x), 8'(y), 4'(z), code);
  endtask

  // Picks a cluster origin, pushed against a grid edge about half of the time.
  function automatic int cluster_origin(int span);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return span - 4;
      default: return $urandom_range(0, span - 4);
    endcase
  endfunction

  initial begin
    int bx;
    int by;
    int bz;
    int random_sent;

    sb = new();

    // Reset is held and then released on a falling edge. The block then clears its
    // memory for a long while with in_tready low; the first send simply waits.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. An air cell gives nothing; a lone corner cell of the grid shows
    // all six faces with every neighbor past the edge counted as air.
    mesh_cell(0, 0, 0, 8'h00);
    put_cell(0, 0, 0, 8'hFF);
    mesh_cell(0, 0, 0, 8'hFF);

    // The opposite grid corner with three inner neighbors: only the outward faces show.
    put_cell(15, 255, 15, 8'h01);
    put_cell(14, 255, 15, 8'h80);
    put_cell(15, 254, 15, 8'h7F);
    put_cell(15, 255, 14, 8'h40);
    mesh_cell(15, 255, 15, 8'h00);

    // A center cell with two side neighbors and a diagonal, so that one corner
    // saturates at the darkest code and others land in between.
    put_cell(8, 128, 8, 8'hA5);
    put_cell(7, 128, 8, 8'h5A);
    put_cell(8, 127, 8, 8'h33);
    put_cell(7, 127, 9, 8'hCC);
    mesh_cell(8, 128, 8, 8'h00);

    // Closing the remaining four faces encloses the cell: no faces at all.
    put_cell(9, 128, 8, 8'h02);
    put_cell(8, 129, 8, 8'h04);
    put_cell(8, 128, 7, 8'h08);
    put_cell(8, 128, 9, 8'h10);
    mesh_cell(8, 128, 8, 8'hFF);

    // Writing air back empties the cell; its neighbor now shows the open face.
    put_cell(8, 128, 8, 8'h00);
    mesh_cell(8, 128, 8, 8'h00);
    mesh_cell(7, 128, 8, 8'h00);

    // Random part. Most of it builds small clusters of solid and air cells inside a
    // 4x4x4 box and then meshes cells of that box, which exercises every mix of
    // occlusion counts. The rest is stray writes and meshes anywhere in the grid.
    random_sent = 0;
    while (random_sent < 125) begin
      if (random_sent >= 100)
        calm_tail = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        bx = cluster_origin(GRID_SIDE);
        by = cluster_origin(GRID_HEIGHT);
        bz = cluster_origin(GRID_SIDE);
        repeat ($urandom_range(6, 14)) begin
          put_cell(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                   bz + $urandom_range(0, 3),
                   ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
          random_sent++;
        end
        repeat ($urandom_range(2, 5)) begin
          mesh_cell(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                    bz + $urandom_range(0, 3), 8'($urandom));
          random_sent++;
        end
      end else begin
        send_item(1'($urandom), 4'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        random_sent++;
      end
    end
    in_tvalid <= 1'b0;

    // Wait for every owed face, then give the block time to show any stray extra one.
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog. The slowest correct run, the memory clear plus the traffic, ends well
  // before the 5 ms limit.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
